### rtl/stepper_phase_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Stepper phase sequencer assertion macros
// Shared concurrent assertion templates for the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef STEPPER_PHASE_SEQUENCER_DEFINES_SVH
`define STEPPER_PHASE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stepper sequencer check failed");

// Next-cycle implication, checked outside reset.
`define SPS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stepper sequencer check failed");

`endif

### rtl/stp_seq_pkg.sv
// ----------------------------------------------------------------------------
// Stepper phase sequencer package
// Widths, request codes, register indexes, states and coil pattern tables.
// ----------------------------------------------------------------------------
package stp_seq_pkg;

    localparam int unsigned TICKS_PER_MINUTE_DEF = 60000000;
    localparam int unsigned STEP_COUNT_BITS_DEF  = 16;

    localparam int unsigned REQ_W    = 2;
    localparam int unsigned STEPS_W  = 16;
    localparam int unsigned PERIOD_W = 26;
    localparam int unsigned PHASE_W  = 3;
    localparam int unsigned COIL_W   = 4;
    localparam int unsigned RPM_W    = 10;
    localparam int unsigned SPR_W    = 10;
    localparam int unsigned GEAR_W   = 8;
    localparam int unsigned PROD1_W  = SPR_W + GEAR_W;
    localparam int unsigned PROD2_W  = PROD1_W + RPM_W;
    localparam int unsigned DEN_W    = PROD2_W + 1;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned S_DATA_W = 24;
    localparam int unsigned M_DATA_W = 24;

    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_RPM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_REV = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GEAR      = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL1 = 4'b0010,
        ST_MUL2 = 4'b0100,
        ST_DIV  = 4'b1000
    } state_t;

    function automatic logic [COIL_W-1:0] full_pattern(input logic [1:0] idx);
        logic [COIL_W-1:0] pat;
        case (idx)
            2'd0:    pat = 4'hC;
            2'd1:    pat = 4'h6;
            2'd2:    pat = 4'h3;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

    function automatic logic [COIL_W-1:0] half_pattern(input logic [PHASE_W-1:0] idx);
        logic [COIL_W-1:0] pat;
        case (idx)
            3'd0:    pat = 4'h8;
            3'd1:    pat = 4'hC;
            3'd2:    pat = 4'h4;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h2;
            3'd5:    pat = 4'h3;
            3'd6:    pat = 4'h1;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

endpackage

### rtl/stepper_phase_sequencer.sv
// ----------------------------------------------------------------------------
// Stepper phase sequencer
// Full-step and half-step coil sequencer for a unipolar stepper motor.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel: tuser carries the request kind (tick,
// start move, stop) and tdata the step count and direction. Every request
// gives exactly one result on the m_ channel with the coil pattern, the busy
// flag, the steps remaining and whether this request stepped the phase.
// Ticks, stops and unused codes have their result registered at the accepting
// edge. A start move computes the step period in multiplier states ST_MUL1
// and ST_MUL2 and then in a restoring divider that produces one quotient bit
// a cycle; s_tready is low meanwhile, until the start's result appears.
// The result sits in an output register; a new request is taken while it is
// being collected, but a stalled receiver holds s_tready low until the
// pending result is taken. Configuration writes on the cfg_ channel are
// always accepted and must be made only while the block is idle.
// Reset (aresetn low, synchronous) returns the control registers to defaults:
// full stepping, 10 rpm, 64 steps per revolution, gear ratio 32, coils off.
// ----------------------------------------------------------------------------
`include "stepper_phase_sequencer_defines.svh"

module stepper_phase_sequencer
    import stp_seq_pkg::*;
#(
    parameter int unsigned TICKS_PER_MINUTE = TICKS_PER_MINUTE_DEF,
    parameter int unsigned STEP_COUNT_BITS  = STEP_COUNT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [15:0] step_count, [16] move_forward, [23:17] zero
    input  logic [S_DATA_W-1:0]   s_tdata,
    // [1:0] req_type
    input  logic [REQ_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [3:0] coil_pattern, [4] busy_res, [20:5] steps_remaining, [21] stepped,
    // [23:22] zero
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned TPM_W   = $clog2(TICKS_PER_MINUTE + 1);
    localparam int unsigned CNT_W   = $clog2(TPM_W);
    localparam int unsigned MASK_W  = (STEP_COUNT_BITS < STEPS_W) ? STEP_COUNT_BITS : STEPS_W;
    localparam logic [STEPS_W-1:0] COUNT_MASK = STEPS_W'((17'd1 << MASK_W) - 17'd1);
    localparam logic [TPM_W-1:0]   TPM_VALUE  = TPM_W'(TICKS_PER_MINUTE);

    state_t               state_reg, state_next;
    logic                 step_mode_reg, step_mode_next;
    logic [RPM_W-1:0]     speed_rpm_reg, speed_rpm_next;
    logic [SPR_W-1:0]     steps_rev_reg, steps_rev_next;
    logic [GEAR_W-1:0]    gear_reg, gear_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [STEPS_W-1:0]   remain_reg, remain_next;
    logic                 dir_fwd_reg, dir_fwd_next;
    logic [PERIOD_W-1:0]  period_reg, period_next;
    logic [PERIOD_W-1:0]  countdown_reg, countdown_next;
    logic [COIL_W-1:0]    coil_reg, coil_next;
    logic                 m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]  m_data_reg, m_data_next;
    logic [PROD1_W-1:0]   prod1_reg, prod1_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [TPM_W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    logic                 s_accept;
    logic                 stepped;
    logic [1:0]           full_idx;
    logic [PHASE_W-1:0]   half_idx;
    logic [PROD2_W-1:0]   prod2;
    logic [DEN_W:0]       trial;
    logic [DEN_W+1:0]     diff;
    logic                 quo_bit;
    logic [TPM_W-1:0]     quo_final;
    logic [PERIOD_W-1:0]  period_calc;

    assign s_tready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign full_idx = dir_fwd_reg ? (phase_reg[1:0] + 2'd1) : (phase_reg[1:0] - 2'd1);
    assign half_idx = dir_fwd_reg ? (phase_reg + 3'd1) : (phase_reg - 3'd1);

    assign prod2   = PROD2_W'(PROD2_W'(prod1_reg) * PROD2_W'(speed_rpm_reg));
    assign trial   = {rem_reg, quo_reg[TPM_W-1]};
    assign diff    = {1'b0, trial} - {2'b00, den_reg};
    assign quo_bit = !diff[DEN_W+1];
    assign quo_final = {quo_reg[TPM_W-2:0], quo_bit};

    always_comb begin
        if (den_reg == '0) begin
            period_calc = '1;
        end else if (quo_final == '0) begin
            period_calc = PERIOD_W'(1);
        end else begin
            period_calc = PERIOD_W'(quo_final);
        end
    end

    always_comb begin
        state_next     = state_reg;
        step_mode_next = step_mode_reg;
        speed_rpm_next = speed_rpm_reg;
        steps_rev_next = steps_rev_reg;
        gear_next      = gear_reg;
        phase_next     = phase_reg;
        remain_next    = remain_reg;
        dir_fwd_next   = dir_fwd_reg;
        period_next    = period_reg;
        countdown_next = countdown_reg;
        coil_next      = coil_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        prod1_next     = prod1_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        stepped        = 1'b0;

        if (cfg_valid) begin
            case (cfg_index)
                CFG_STEP_MODE: step_mode_next = cfg_data[0];
                CFG_SPEED_RPM: speed_rpm_next = cfg_data[RPM_W-1:0];
                CFG_STEPS_REV: steps_rev_next = cfg_data[SPR_W-1:0];
                CFG_GEAR:      gear_next      = cfg_data[GEAR_W-1:0];
                default:       step_mode_next = step_mode_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (s_tuser)
                        REQ_TICK: begin
                            if (remain_reg != '0) begin
                                if (countdown_reg <= PERIOD_W'(1)) begin
                                    if (step_mode_reg) begin
                                        phase_next = half_idx;
                                        coil_next  = half_pattern(half_idx);
                                    end else begin
                                        phase_next = {1'b0, full_idx};
                                        coil_next  = full_pattern(full_idx);
                                    end
                                    remain_next    = remain_reg - STEPS_W'(1);
                                    countdown_next = period_reg;
                                    stepped        = 1'b1;
                                end else begin
                                    countdown_next = countdown_reg - PERIOD_W'(1);
                                end
                            end
                        end
                        REQ_START: begin
                            remain_next  = s_tdata[STEPS_W-1:0] & COUNT_MASK;
                            dir_fwd_next = s_tdata[STEPS_W];
                            phase_next   = '0;
                            state_next   = ST_MUL1;
                        end
                        REQ_STOP: begin
                            remain_next    = '0;
                            countdown_next = '0;
                            coil_next      = '0;
                        end
                        default: begin
                            stepped = 1'b0;
                        end
                    endcase
                    if (s_tuser != REQ_START) begin
                        m_valid_next = 1'b1;
                        m_data_next  = {2'b00, stepped, remain_next,
                                        (remain_next != '0), coil_next};
                    end
                end
            end
            ST_MUL1: begin
                prod1_next = PROD1_W'(PROD1_W'(steps_rev_reg) * PROD1_W'(gear_reg));
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                den_next   = step_mode_reg ? {prod2, 1'b0} : {1'b0, prod2};
                rem_next   = '0;
                quo_next   = TPM_VALUE;
                cnt_next   = CNT_W'(TPM_W - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rem_next = quo_bit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                quo_next = quo_final;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    period_next    = period_calc;
                    countdown_next = period_calc;
                    m_valid_next   = 1'b1;
                    m_data_next    = {2'b00, 1'b0, remain_reg,
                                      (remain_reg != '0), coil_reg};
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_mode_reg <= 1'b0;
            speed_rpm_reg <= RPM_W'(10);
            steps_rev_reg <= SPR_W'(64);
            gear_reg      <= GEAR_W'(32);
            phase_reg     <= '0;
            remain_reg    <= '0;
            dir_fwd_reg   <= 1'b1;
            period_reg    <= '0;
            countdown_reg <= '0;
            coil_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_mode_reg <= step_mode_next;
            speed_rpm_reg <= speed_rpm_next;
            steps_rev_reg <= steps_rev_next;
            gear_reg      <= gear_next;
            phase_reg     <= phase_next;
            remain_reg    <= remain_next;
            dir_fwd_reg   <= dir_fwd_next;
            period_reg    <= period_next;
            countdown_reg <= countdown_next;
            coil_reg      <= coil_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        prod1_reg  <= prod1_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
    end

    // A result never waits while a period is being computed.
    `SPS_ASSERT_NOW(a_no_result_while_busy, aclk, aresetn, state_reg != ST_IDLE, !m_valid_reg)

    // A running move always has a non-zero step period.
    `SPS_ASSERT_NOW(a_period_set, aclk, aresetn,
        (state_reg == ST_IDLE) && (remain_reg != '0), period_reg != '0)

    // A stepping result always drives at least one coil.
    `SPS_ASSERT_NOW(a_step_drives_coil, aclk, aresetn,
        m_valid_reg && m_data_reg[21], m_data_reg[3:0] != '0)

    // A start request leads straight into the multiplier sequence.
    `SPS_ASSERT_NEXT(a_start_computes, aclk, aresetn,
        s_accept && (s_tuser == REQ_START), state_reg == ST_MUL1)

endmodule

### tb/tb_stepper_phase_sequencer.sv
// ----------------------------------------------------------------------------
// Stepper phase sequencer testbench
// Sends tick, start-move, stop and unused requests at random pace through the
// stream input. Each accepted request is predicted in a scoreboard that
// tracks phase, countdown and coil state, and each result is compared with
// the expected one. Runs cover full and half stepping, extreme speed settings
// and a long receiver hold-off that makes the block stall its input.
// ----------------------------------------------------------------------------
module tb_stepper_phase_sequencer;
    import stp_seq_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic [15:0] FULL_SEQ = 16'h9_3_6_C;
    localparam logic [31:0] HALF_SEQ = 32'h9_1_3_2_6_4_C_8;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;
    localparam int unsigned WATCHDOG_LIMIT  = 5000;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned RANDOM_PHASES   = 8;
    localparam int unsigned PHASE_REQUESTS  = 75;

    typedef struct packed {
        logic               stepped;
        logic [STEPS_W-1:0] steps;
        logic               busy;
        logic [COIL_W-1:0]  coil;
    } coil_result_t;

    class coil_scoreboard;
        bit                half_mode;
        bit [RPM_W-1:0]    rpm;
        bit [SPR_W-1:0]    spr;
        bit [GEAR_W-1:0]   gear;
        bit [PHASE_W-1:0]  phase;
        bit [STEPS_W-1:0]  remaining;
        bit                forward;
        bit [PERIOD_W-1:0] period;
        bit [PERIOD_W-1:0] countdown;
        bit [COIL_W-1:0]   coils;
        coil_result_t      expected_results[$];
        int unsigned       errors;
        int unsigned       requests;
        int unsigned       results;
        int unsigned       steps_taken;

        function new();
            half_mode = 1'b0;
            rpm       = 10;
            spr       = 64;
            gear      = 32;
            phase     = '0;
            remaining = '0;
            forward   = 1'b1;
            period    = '0;
            countdown = '0;
            coils     = '0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_STEP_MODE: half_mode = value[0];
                CFG_SPEED_RPM: rpm = value[RPM_W-1:0];
                CFG_STEPS_REV: spr = value[SPR_W-1:0];
                CFG_GEAR:      gear = value[GEAR_W-1:0];
                default: ;
            endcase
        endfunction

        function bit [PERIOD_W-1:0] step_period();
            longint unsigned den;
            longint unsigned quot;
            den = 64'(spr) * 64'(gear) * (half_mode ? 64'd2 : 64'd1) * 64'(rpm);
            if (den == 0)
                return PERIOD_MAX;
            quot = 64'(TICKS_PER_MINUTE_DEF) / den;
            if (quot > 64'(PERIOD_MAX))
                quot = 64'(PERIOD_MAX);
            if (quot == 0)
                quot = 1;
            return quot[PERIOD_W-1:0];
        endfunction

        function void advance_phase();
            bit [1:0] quarter;
            if (half_mode) begin
                phase = forward ? phase + 3'd1 : phase - 3'd1;
                coils = HALF_SEQ[{phase, 2'b00} +: 4];
            end else begin
                quarter = phase[1:0];
                quarter = forward ? quarter + 2'd1 : quarter - 2'd1;
                phase = {1'b0, quarter};
                coils = FULL_SEQ[{quarter, 2'b00} +: 4];
            end
        endfunction

        function void note_request(logic [REQ_W-1:0] kind, logic [STEPS_W-1:0] count,
                                   logic move_fwd);
            coil_result_t res;
            bit did_step;
            did_step = 1'b0;
            case (kind)
                REQ_START: begin
                    remaining = count;
                    forward   = move_fwd;
                    phase     = '0;
                    period    = step_period();
                    countdown = period;
                end
                REQ_STOP: begin
                    remaining = '0;
                    countdown = '0;
                    coils     = '0;
                end
                REQ_TICK: begin
                    if (remaining != 0) begin
                        if (countdown <= 1) begin
                            advance_phase();
                            remaining = remaining - 1'b1;
                            countdown = period;
                            did_step  = 1'b1;
                        end else begin
                            countdown = countdown - 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            res.coil    = coils;
            res.busy    = (remaining != 0);
            res.steps   = remaining;
            res.stepped = did_step;
            expected_results.push_back(res);
            requests++;
            if (did_step)
                steps_taken++;
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data);
            coil_result_t got;
            coil_result_t want;
            got = data[$bits(coil_result_t)-1:0];
            results++;
            if (expected_results.size() == 0) begin
                $error("Result %h arrived with no request outstanding.", data);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.coil !== want.coil) begin
                $error("coil_pattern: expected %h, got %h", want.coil, got.coil);
                errors++;
            end
            if (got.busy !== want.busy) begin
                $error("busy_res: expected %0d, got %0d", want.busy, got.busy);
                errors++;
            end
            if (got.steps !== want.steps) begin
                $error("steps_remaining: expected %0d, got %0d", want.steps, got.steps);
                errors++;
            end
            if (got.stepped !== want.stepped) begin
                $error("stepped: expected %0d, got %0d", want.stepped, got.stepped);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [REQ_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    coil_scoreboard sb;
    bit             tx_eager;
    bit             rx_eager;
    bit             long_hold;
    int unsigned    idle_cycles;
    int unsigned    cfg_writes;

    stepper_phase_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 2);
        else if (r < 90)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // Results are checked before the request of the same edge is noted, as a
    // result can never belong to a request accepted at that very edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata[STEPS_W-1:0], s_tdata[STEPS_W]);
            if (cfg_valid && cfg_ready)
                sb.write_register(cfg_index, cfg_data);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles.", WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                long_hold = 1'b0;
                m_tready  = 1'b1;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else if (!rx_eager && $urandom_range(0, 99) < 20) begin
                stall_left = idle_length() - 1;
                m_tready   = 1'b0;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // The valid stays high from one request to the next unless a random gap is drawn; sender_idle lowers it.
    task automatic send_request(input logic [REQ_W-1:0] kind, input logic [STEPS_W-1:0] count,
                                input logic move_fwd);
        int gap;
        gap = (!tx_eager && $urandom_range(0, 99) < 30) ? idle_length() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {{(S_DATA_W - STEPS_W - 1){1'b0}}, move_fwd, count};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic sender_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic drain();
        sender_idle();
        do @(negedge aclk); while (sb.expected_results.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_writes++;
    endtask

    task automatic apply_settings(input bit half, input int rpm, input int spr, input int gear);
        drain();
        write_cfg(CFG_STEP_MODE, CFG_DATA_W'(half));
        write_cfg(CFG_SPEED_RPM, CFG_DATA_W'(rpm));
        write_cfg(CFG_STEPS_REV, CFG_DATA_W'(spr));
        write_cfg(CFG_GEAR, CFG_DATA_W'(gear));
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_request();
        int r;
        int c;
        logic [STEPS_W-1:0] count;
        r = $urandom_range(0, 99);
        c = $urandom_range(0, 99);
        if (c < 70)
            count = STEPS_W'($urandom_range(1, 12));
        else if (c < 80)
            count = '0;
        else
            count = STEPS_W'($urandom());
        if (r < 78)
            send_request(REQ_TICK, STEPS_W'($urandom()), 1'($urandom()));
        else if (r < 90)
            send_request(REQ_START, count, 1'($urandom_range(0, 1)));
        else if (r < 97)
            send_request(REQ_STOP, STEPS_W'($urandom()), 1'($urandom()));
        else
            send_request(REQ_UNUSED, STEPS_W'($urandom()), 1'($urandom()));
    endtask

    initial begin
        int p;
        int k;
        bit all_ok;
        sb          = new();
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = REQ_TICK;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_STEP_MODE;
        cfg_data    = '0;
        tx_eager    = 1'b0;
        rx_eager    = 1'b0;
        long_hold   = 1'b0;
        idle_cycles = 0;
        cfg_writes  = 0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings: idle tick, unused code, empty move, slow move, tick, stop.
        send_request(REQ_TICK, 16'h0000, 1'b0);
        send_request(REQ_UNUSED, 16'h0000, 1'b0);
        send_request(REQ_START, 16'h0000, 1'b1);
        send_request(REQ_START, 16'd2, 1'b0);
        send_request(REQ_TICK, 16'h0000, 1'b0);
        send_request(REQ_STOP, 16'h0000, 1'b0);

        // Largest divisor: the quotient is zero and saturates to one tick.
        apply_settings(1'b0, 1023, 1023, 255);
        send_request(REQ_START, 16'hFFFF, 1'b1);
        repeat (4) send_request(REQ_TICK, 16'hFFFF, 1'b1);
        send_request(REQ_UNUSED, 16'hFFFF, 1'b1);
        send_request(REQ_STOP, 16'h0000, 1'b0);
        send_request(REQ_START, 16'd3, 1'b0);
        repeat (4) send_request(REQ_TICK, 16'h0000, 1'b0);

        // Half stepping, then a switch to full stepping in the middle of a move.
        apply_settings(1'b1, 1023, 1023, 255);
        send_request(REQ_START, 16'd5, 1'b1);
        repeat (3) send_request(REQ_TICK, 16'h0000, 1'b0);
        apply_settings(1'b0, 1023, 1023, 255);
        repeat (2) send_request(REQ_TICK, 16'h0000, 1'b0);

        // A zero speed makes the divisor zero and the period saturates.
        apply_settings(1'b0, 0, 1023, 255);
        send_request(REQ_START, 16'd1, 1'b1);
        send_request(REQ_TICK, 16'h0000, 1'b0);

        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: apply_settings(1'($urandom()), 1023, 1023, 255);
                1: apply_settings(1'($urandom()), 1, 1, 1);
                7: apply_settings(1'b0, 10, 64, 32);
                default: apply_settings(1'($urandom()), $urandom_range(100, 1023),
                                        $urandom_range(500, 1023), $urandom_range(100, 255));
            endcase
            tx_eager = ($urandom_range(0, 3) == 0);
            rx_eager = ($urandom_range(0, 3) == 0);
            if (p == 3) begin
                tx_eager  = 1'b1;
                rx_eager  = 1'b0;
                long_hold = 1'b1;
            end
            for (k = 0; k < PHASE_REQUESTS; k++)
                random_request();
        end

        drain();
        repeat (40) @(negedge aclk);
        all_ok = (sb.errors == 0) && (sb.expected_results.size() == 0);
        if (sb.expected_results.size() != 0)
            $error("%0d expected results never arrived.", sb.expected_results.size());
        $display("Run covered %0d requests, %0d results, %0d phase steps and %0d register writes.",
                 sb.requests, sb.results, sb.steps_taken, cfg_writes);
        if (all_ok) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### stepper_phase_sequencer.f
+incdir+rtl
rtl/stp_seq_pkg.sv
rtl/stepper_phase_sequencer.sv
tb/tb_stepper_phase_sequencer.sv
